>>> hdl/lvbr_pkg.sv
// ----------------------------------------------------------------------------
// lvbr_pkg
// shared types, constants and helpers for the longest valid bracket run block
// ----------------------------------------------------------------------------
package lvbr_pkg;

  localparam int unsigned MaxLenDef = 1024;
  localparam int unsigned RunOutW   = 11;
  localparam int unsigned SymW      = 8;
  localparam int unsigned OutDataW  = 24;

  localparam logic [SymW-1:0] OpenChar  = 8'h28;
  localparam logic [SymW-1:0] CloseChar = 8'h29;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_CLOSE = 2'd2
  } sym_class_e;

  // what the look-back of one beat has to resolve
  typedef enum logic [1:0] {
    LB_NONE = 2'd0,
    LB_PAIR = 2'd1,
    LB_SKIP = 2'd2
  } lookback_e;

  function automatic sym_class_e classify(input logic [SymW-1:0] sym);
    sym_class_e c;
    c = CLS_OTHER;
    if (sym == OpenChar) begin
      c = CLS_OPEN;
    end else if (sym == CloseChar) begin
      c = CLS_CLOSE;
    end
    return c;
  endfunction

endpackage

>>> hdl/longest_valid_bracket_run_top.sv
// ----------------------------------------------------------------------------
// longest_valid_bracket_run_top
// per character length of the longest well-formed bracket run ending there
// ----------------------------------------------------------------------------
// latency: a taken input beat is held in the look-back stage, and its result is
//   registered into the output register when that stage fires, which waits on a stalled output
// pacing: a new beat is not taken until the previous one has left the look-back stage,
//   bound by the look-back read of the class and run memories followed by the write-back of the same beat
// reset: control and string state cleared at once, no clearing pass; memory
//   entries are undefined until written and their read data is only used once written
// ----------------------------------------------------------------------------
module longest_valid_bracket_run_top
  import lvbr_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SymW-1:0]     s_axis_tdata,   // symbol[7:0]
  input  logic                s_axis_tuser,   // start_of_string
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // run_ending_here[10:0], best_length[21:11]
  output logic                m_axis_tuser    // overflow
);

  localparam int unsigned AW = $clog2(MaxLen);
  localparam int unsigned PW = $clog2(MaxLen + 1);

  // string state
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] best_q, best_d;
  logic [PW-1:0] prun_q, prun_d;
  sym_class_e    pcls_q, pcls_d;
  logic          ovf_q, ovf_d;

  // look-back stage
  logic          s1_valid_q, s1_valid_d;
  lookback_e     s1_kind_q, s1_kind_d;
  logic          s1_ok_q, s1_ok_d;
  logic          s1_run_ok_q, s1_run_ok_d;
  logic [PW-1:0] s1_m_q;
  sym_class_e    s1_cls_q;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic                out_ovf_q;

  logic          accept, fire, over;
  logic [PW-1:0] eff_pos, eff_prun, ix;
  sym_class_e    eff_pcls, cls;
  logic [AW-1:0] c_raddr, r_raddr;
  logic [1:0]    c_rdata;
  logic [PW-1:0] r_rdata;
  logic [PW:0]   run_sum;
  logic [PW-1:0] run_s1, best_new;
  logic          mem_we;

  assign s_axis_tready = !s1_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign over          = (pos_q >= PW'(MaxLen));
  assign mem_we        = fire && !over;

  // look-back address generation
  always_comb begin
    cls         = classify(s_axis_tdata);
    eff_pos     = s_axis_tuser ? '0 : pos_q;
    eff_prun    = s_axis_tuser ? '0 : prun_q;
    eff_pcls    = s_axis_tuser ? CLS_OTHER : pcls_q;
    ix          = eff_pos - eff_prun - PW'(1);
    s1_kind_d   = LB_NONE;
    s1_ok_d     = 1'b0;
    s1_run_ok_d = 1'b0;
    c_raddr     = '0;
    r_raddr     = '0;
    if (cls == CLS_CLOSE) begin
      if (eff_pcls == CLS_OPEN) begin
        s1_kind_d   = LB_PAIR;
        s1_run_ok_d = (eff_pos >= PW'(2));
        r_raddr     = AW'(eff_pos - PW'(2));
      end else begin
        s1_kind_d   = LB_SKIP;
        s1_ok_d     = (eff_pos > eff_prun);
        s1_run_ok_d = (ix != '0);
        c_raddr     = AW'(ix);
        r_raddr     = AW'(ix - PW'(1));
      end
    end
  end

  // run length resolution
  always_comb begin
    run_sum = '0;
    case (s1_kind_q)
      LB_PAIR: begin
        run_sum = (PW+1)'(2) + (s1_run_ok_q ? {1'b0, r_rdata} : '0);
      end
      LB_SKIP: begin
        if (s1_ok_q && (sym_class_e'(c_rdata) == CLS_OPEN)) begin
          run_sum = {1'b0, s1_m_q} + (PW+1)'(2) + (s1_run_ok_q ? {1'b0, r_rdata} : '0);
        end
      end
      default: begin
        run_sum = '0;
      end
    endcase
    if (over) begin
      run_sum = '0;
    end
    run_s1   = PW'(run_sum);
    best_new = (run_s1 > best_q) ? run_s1 : best_q;
  end

  // next state
  always_comb begin
    pos_d       = pos_q;
    best_d      = best_q;
    prun_d      = prun_q;
    pcls_d      = pcls_q;
    ovf_d       = ovf_q;
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
      if (s_axis_tuser) begin
        pos_d  = '0;
        best_d = '0;
        prun_d = '0;
        pcls_d = CLS_OTHER;
        ovf_d  = 1'b0;
      end
    end
    if (fire) begin
      s1_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      if (over) begin
        ovf_d = 1'b1;
      end else begin
        pos_d  = pos_q + PW'(1);
        best_d = best_new;
        prun_d = run_s1;
        pcls_d = s1_cls_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      best_q      <= '0;
      prun_q      <= '0;
      pcls_q      <= CLS_OTHER;
      ovf_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_kind_q   <= LB_NONE;
      s1_ok_q     <= 1'b0;
      s1_run_ok_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      best_q      <= best_d;
      prun_q      <= prun_d;
      pcls_q      <= pcls_d;
      ovf_q       <= ovf_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        s1_kind_q   <= s1_kind_d;
        s1_ok_q     <= s1_ok_d;
        s1_run_ok_q <= s1_run_ok_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_m_q   <= eff_prun;
      s1_cls_q <= cls;
    end
    if (fire) begin
      out_data_q <= {(OutDataW - 2*RunOutW)'(0), RunOutW'(best_new), RunOutW'(run_s1)};
      out_ovf_q  <= ovf_q | over;
    end
  end

  lvbr_ram #(
    .Width (2),
    .Depth (MaxLen)
  ) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(pos_q)),
    .wdata_i (s1_cls_q),
    .re_i    (accept),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  lvbr_ram #(
    .Width (PW),
    .Depth (MaxLen)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(pos_q)),
    .wdata_i (run_s1),
    .re_i    (accept),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

  // a look-back read never shares a cycle with the write-back
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && accept))
    else $error("memory read and write in the same cycle");

  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MaxLen))
    else $error("position past max length");

  a_pos_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (pos_q == $past(pos_q) + PW'(1)))
    else $error("position not advanced after write-back");

  a_best_ge_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[RunOutW-1:0] <= m_axis_tdata[2*RunOutW-1:RunOutW]))
    else $error("best length below current run");

  a_ovf_zero_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser && (pos_q >= PW'(MaxLen)))
      |-> (m_axis_tdata[RunOutW-1:0] == '0))
    else $error("run reported on an ignored beat");

endmodule

>>> hdl/lvbr_ram.sv
// ----------------------------------------------------------------------------
// lvbr_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lvbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
